@@ design/spx_pkg.sv @@
// ----------------------------------------------------------------------------
// spx_pkg
// Shared types for the simplex projection block.
// ----------------------------------------------------------------------------
package spx_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam int unsigned ELEM_W = 32;
    localparam int unsigned SIZE_W = 31;
    localparam int unsigned TOL_W  = 16;

endpackage

@@ design/simplex_projection.sv @@
// ----------------------------------------------------------------------------
// simplex_projection
// Euclidean projection of a streamed vector onto the simplex.
// ----------------------------------------------------------------------------
// Load: each element is written to the element memory and inserted into the
//   sorted memory by an insertion sort that shifts larger entries up.
// Close: setup, then up to n divisions in the serial divider (SW = 41, the
//   serial divider width), then the results, each held under output stall.
// Synchronous active-low reset clears control, count and total; memories
//   are not cleared. Not ready while an element is sorted or a vector closed.
module simplex_projection
    import spx_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] projected
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
    localparam int unsigned SW = ELEM_W + 1 + CW + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_CLOSE, ST_SC_LATCH, ST_SC_STEP,
        ST_SC_WAIT, ST_FIN_WAIT, ST_OUT_RD, ST_OUT_SH, ST_OUT_WAIT
    } t_state;

    logic [SIZE_W-1:0] r_size;
    logic [TOL_W-1:0]  r_tol;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_j, n_j;
    logic signed [SW-1:0] r_total, n_total;
    logic signed [SW-1:0] r_acc, n_acc;
    logic signed [SW-1:0] r_thr, n_thr;
    logic signed [ELEM_W-1:0] r_v, n_v;
    logic signed [ELEM_W-1:0] r_cur, n_cur;
    logic r_last, n_last;
    logic r_pass, n_pass;
    logic [31:0] r_odata, n_odata;
    logic r_ovalid, n_ovalid;
    logic r_olast, n_olast;

    logic signed [ELEM_W-1:0] r_elem [MAX_LENGTH];
    logic signed [ELEM_W-1:0] r_sort [MAX_LENGTH];
    logic signed [ELEM_W-1:0] r_erd;
    logic signed [ELEM_W-1:0] r_srd;

    logic          e_we;
    logic [AW-1:0] e_waddr;
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic signed [ELEM_W-1:0] s_wdata;
    logic [AW-1:0] e_raddr;
    logic [AW-1:0] s_raddr;

    logic                 div_start;
    logic signed [SW-1:0] div_num;
    logic [CW-1:0]        div_den;
    t_div_stat            div_stat;
    logic signed [SW-1:0] div_quo;

    logic signed [SW-1:0] diff;
    logic [SW-1:0]        adiff;
    logic signed [SW-1:0] size_x;
    logic signed [SW:0]   res;
    logic                 in_acc;

    spx_div #(.W(SW), .CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(32-TOL_W){1'b0}}, r_tol} : {1'b0, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(65536);
            r_tol  <= TOL_W'(1);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_tol <= pwdata[TOL_W-1:0];
            end else begin
                r_size <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    assign size_x = SW'({1'b0, r_size});
    assign diff   = r_total - size_x;
    assign adiff  = diff[SW-1] ? (~diff + SW'(1)) : diff;
    assign res    = {r_erd[ELEM_W-1], SW'(r_erd)} - {r_thr[SW-1], r_thr};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_total  = r_total;
        n_acc    = r_acc;
        n_thr    = r_thr;
        n_v      = r_v;
        n_cur    = r_cur;
        n_last   = r_last;
        n_pass   = r_pass;
        n_odata  = r_odata;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        e_we     = 1'b0;
        e_waddr  = r_cnt[AW-1:0];
        s_we     = 1'b0;
        s_waddr  = r_j[AW-1:0];
        s_wdata  = r_v;
        e_raddr  = r_j[AW-1:0];
        s_raddr  = r_j[AW-1:0] - AW'(1);
        div_start = 1'b0;
        div_num   = r_total - size_x;
        div_den   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = s_axis_tlast;
                    n_v    = s_axis_tdata;
                    if (r_cnt < CW'(MAX_LENGTH)) begin
                        e_we    = 1'b1;
                        n_total = r_total + SW'($signed(s_axis_tdata));
                        n_cnt   = r_cnt + CW'(1);
                        n_j     = r_cnt;
                        n_state = ST_INS_RD;
                    end else if (s_axis_tlast) begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_j == '0) begin
                    s_we    = 1'b1;
                    n_state = r_last ? ST_CLOSE : ST_IDLE;
                end else begin
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                s_we = 1'b1;
                if (r_srd > r_v) begin
                    s_wdata = r_srd;
                    n_j     = r_j - CW'(1);
                    n_state = ST_INS_RD;
                end else begin
                    n_state = r_last ? ST_CLOSE : ST_IDLE;
                end
            end
            ST_CLOSE: begin
                n_j   = r_cnt - CW'(1);
                n_acc = '0;
                if (adiff < SW'(r_tol)) begin
                    n_pass  = 1'b1;
                    n_j     = '0;
                    n_state = ST_OUT_RD;
                end else if (r_cnt == CW'(1)) begin
                    n_pass    = 1'b0;
                    div_start = 1'b1;
                    n_state   = ST_FIN_WAIT;
                end else begin
                    n_pass  = 1'b0;
                    s_raddr = n_j[AW-1:0];
                    n_state = ST_SC_LATCH;
                end
            end
            ST_SC_LATCH: begin
                n_cur   = r_srd;
                n_state = ST_SC_STEP;
            end
            ST_SC_STEP: begin
                n_acc     = r_acc + SW'(r_cur);
                div_start = 1'b1;
                div_num   = n_acc - size_x;
                div_den   = r_cnt - r_j;
                n_state   = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                s_raddr = r_j[AW-1:0] - AW'(1);
                if (div_stat.done) begin
                    if (div_quo >= SW'(r_srd)) begin
                        n_thr   = div_quo;
                        n_j     = '0;
                        n_state = ST_OUT_RD;
                    end else begin
                        n_cur = r_srd;
                        n_j   = r_j - CW'(1);
                        if (r_j == CW'(1)) begin
                            div_start = 1'b1;
                            n_state   = ST_FIN_WAIT;
                        end else begin
                            n_state = ST_SC_STEP;
                        end
                    end
                end
            end
            ST_FIN_WAIT: begin
                if (div_stat.done) begin
                    n_thr   = div_quo;
                    n_j     = '0;
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_SH;
            end
            ST_OUT_SH: begin
                if (r_pass) begin
                    n_odata = r_erd;
                end else if (res[SW]) begin
                    n_odata = '0;
                end else if (res > (SW+1)'(32'h7FFF_FFFF)) begin
                    n_odata = 32'h7FFF_FFFF;
                end else begin
                    n_odata = res[31:0];
                end
                n_ovalid = 1'b1;
                n_olast  = (r_j + CW'(1) == r_cnt);
                n_state  = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_j      = r_j + CW'(1);
                    if (r_olast) begin
                        n_cnt   = '0;
                        n_total = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_j      <= '0;
            r_last   <= 1'b0;
            r_pass   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            r_olast  <= n_olast;
            r_j      <= n_j;
            r_last   <= n_last;
            r_pass   <= n_pass;
        end
        r_acc   <= n_acc;
        r_thr   <= n_thr;
        r_v     <= n_v;
        r_cur   <= n_cur;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_elem[e_waddr] <= s_axis_tdata;
        end
        r_erd <= r_elem[e_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sort[s_waddr] <= s_wdata;
        end
        r_srd <= r_sort[s_raddr];
    end

endmodule

@@ design/spx_div.sv @@
// ----------------------------------------------------------------------------
// spx_div
// Restoring divider, one quotient bit per cycle, floor rounding of a signed
// numerator by a positive unsigned count.
// ----------------------------------------------------------------------------
module spx_div
    import spx_pkg::*;
#(
    parameter int unsigned W  = 40,
    parameter int unsigned CW = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic [CW-1:0]       i_den,
    output t_div_stat           o_stat,
    output logic signed [W-1:0] o_quo
);

    localparam int unsigned NW = $clog2(W + 1);

    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [W-1:0]  r_quo;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_den;

    logic [CW:0]   rs;
    logic          ge;
    logic [CW:0]   rdiff;

    assign rs    = {r_rem, r_quo[W-1]};
    assign ge    = rs >= {1'b0, r_den};
    assign rdiff = rs - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(W);
                r_neg  <= i_num[W-1];
                r_quo  <= i_num[W-1] ? (~i_num + W'(1)) : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? rdiff[CW-1:0] : rs[CW-1:0];
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo = r_neg ? (~r_quo + W'(1) - W'(r_rem != '0)) : r_quo;

endmodule

@@ design/spx_checker.sv @@
// ----------------------------------------------------------------------------
// spx_checker
// Port-level checks for the simplex projection block.
// ----------------------------------------------------------------------------
module spx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input taken while result pending");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("result after last");

    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind simplex_projection spx_checker u_spx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
